// ----- hdl/hrp_pkg.sv -----
// Shared types, codes and match tables of the HTTP request header parser.
`default_nettype none

package hrp_pkg;

  localparam int HRP_MAX_HEADERS = 64;
  localparam int HRP_LENGTH_BITS = 16;

  localparam logic [6:0] HDR_LIMIT_RESET = 7'd64;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  localparam int         METH_NUM = 9;
  localparam logic [3:0] VER_LEN  = 4'd5;

  typedef enum logic [2:0] {
    ROLE_SKIP     = 3'd0,
    ROLE_METHOD   = 3'd1,
    ROLE_URI      = 3'd2,
    ROLE_VERSION  = 3'd3,
    ROLE_HNAME    = 3'd4,
    ROLE_HVALUE   = 3'd5,
    ROLE_TERM     = 3'd6,
    ROLE_UNPARSED = 3'd7
  } role_t;

  typedef enum logic [2:0] {
    ST_BUSY        = 3'd0,
    ST_COMPLETE    = 3'd1,
    ST_INCOMPLETE  = 3'd2,
    ST_BAD_CHAR    = 3'd3,
    ST_BAD_METHOD  = 3'd4,
    ST_BAD_VERSION = 3'd5,
    ST_BAD_LINE    = 3'd6,
    ST_TOO_LONG    = 3'd7
  } status_t;

  localparam logic [3:0] METH_NONE = 4'd0;

  // Method names, zero padded to eight characters; codes are index + 1.
  localparam logic [7:0] METH_NAME [0:8][0:7] = '{
    '{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"P", "O", "S", "T", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"H", "E", "A", "D", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"C", "O", "N", "N", "E", "C", "T", 8'h00},
    '{"P", "U", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"D", "E", "L", "E", "T", "E", 8'h00, 8'h00},
    '{"O", "P", "T", "I", "O", "N", "S", 8'h00},
    '{"P", "R", "O", "P", "F", "I", "N", "D"},
    '{"M", "K", "C", "O", "L", 8'h00, 8'h00, 8'h00}
  };

  localparam logic [3:0] METH_LEN [0:8] = '{
    4'd3, 4'd4, 4'd4, 4'd7, 4'd3, 4'd6, 4'd7, 4'd8, 4'd5
  };

  localparam logic [7:0] VER_PREFIX [0:7] = '{
    "H", "T", "T", "P", "/", 8'h00, 8'h00, 8'h00
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } hrp_in_t;

  typedef struct packed {
    role_t       byte_role;
    logic [5:0]  header_index;
    logic [3:0]  method_code;
    logic [6:0]  header_count;
    logic [15:0] msg_len;
    status_t     parse_status;
    logic        done_res;
  } hrp_out_t;

  typedef struct packed {
    logic       accept;
    logic [6:0] header_limit;
  } hrp_ctl_t;

endpackage

`default_nettype wire

// ----- hdl/hrp_if.sv -----
// Valid/ready channel interfaces of the HTTP request header parser.
`default_nettype none

interface hrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, data_byte, first_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface hrp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  byte_role;
  logic [5:0]  header_index;
  logic [3:0]  method_code;
  logic [6:0]  header_count;
  logic [15:0] msg_len;
  logic [2:0]  parse_status;
  logic        done_res;

  modport source (output valid, byte_role, header_index, method_code, header_count,
                  msg_len, parse_status, done_res, input ready);
  modport sink   (input valid, byte_role, header_index, method_code, header_count,
                  msg_len, parse_status, done_res, output ready);
endinterface

interface hrp_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ----- hdl/hrp_core.sv -----
// Per-byte parse state, byte classification and result register.
`default_nettype none

module hrp_core
  import hrp_pkg::*;
#(
  parameter int MAX_HEADERS = HRP_MAX_HEADERS,
  parameter int LENGTH_BITS = HRP_LENGTH_BITS
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire hrp_ctl_t ctl,
  input  wire hrp_in_t  in_item,
  output hrp_out_t      res_r
);

  localparam int HS_W  = $clog2(MAX_HEADERS + 1);
  localparam int CMP_W = (HS_W > 7) ? HS_W : 7;

  typedef enum logic [3:0] {
    PH_WS       = 4'd0,
    PH_METHOD   = 4'd1,
    PH_URI      = 4'd2,
    PH_VERSION  = 4'd3,
    PH_DELIM    = 4'd4,
    PH_NAME     = 4'd5,
    PH_COLSP    = 4'd6,
    PH_VALUE    = 4'd7,
    PH_UNPARSED = 4'd8,
    PH_FINAL    = 4'd9
  } phase_t;

  phase_t                 phase_r,  phase_nxt;
  logic [LENGTH_BITS-1:0] cnt_r,    cnt_nxt;
  logic [1:0]             term_r,   term_nxt;
  logic [METH_NUM-1:0]    cand_r,   cand_nxt;
  logic [3:0]             tpos_r,   tpos_nxt;
  logic [HS_W-1:0]        hs_r,     hs_nxt;
  logic                   nempty_r, nempty_nxt;
  status_t                status_r, status_nxt;
  logic [3:0]             mcode_r,  mcode_nxt;
  logic                   verok_r,  verok_nxt;
  logic [LENGTH_BITS-1:0] flen_r,   flen_nxt;
  hrp_out_t               res_nxt;

  always_comb begin
    logic [7:0]      b;
    logic            fin;
    logic            bad;
    logic            at_limit;
    role_t           role;
    logic [HS_W-1:0] hidx;

    b   = in_item.data_byte;
    fin = 1'b0;
    role = ROLE_UNPARSED;
    hidx = '0;

    // Start of a request clears the parse before this byte is handled.
    if (in_item.first_byte) begin
      phase_nxt  = PH_WS;
      cnt_nxt    = '0;
      term_nxt   = 2'd0;
      cand_nxt   = '1;
      tpos_nxt   = 4'd0;
      hs_nxt     = '0;
      nempty_nxt = 1'b1;
      status_nxt = ST_BUSY;
      mcode_nxt  = METH_NONE;
      verok_nxt  = 1'b1;
      flen_nxt   = '0;
    end else begin
      phase_nxt  = phase_r;
      cnt_nxt    = cnt_r;
      term_nxt   = term_r;
      cand_nxt   = cand_r;
      tpos_nxt   = tpos_r;
      hs_nxt     = hs_r;
      nempty_nxt = nempty_r;
      status_nxt = status_r;
      mcode_nxt  = mcode_r;
      verok_nxt  = verok_r;
      flen_nxt   = flen_r;
    end

    bad = (b < 8'h80) && (b != CH_CR) && (b != CH_LF) && ((b < CH_SP) || (b == CH_DEL));
    at_limit = (CMP_W'(hs_nxt) >= CMP_W'(MAX_HEADERS)) ||
               (CMP_W'(hs_nxt) >= CMP_W'(ctl.header_limit));

    if (phase_nxt != PH_FINAL) begin
      if (cnt_nxt == '1) begin
        status_nxt = ST_TOO_LONG;
        flen_nxt   = '1;
        phase_nxt  = PH_FINAL;
      end else begin
        cnt_nxt = cnt_nxt + 1'b1;
        if (bad) begin
          status_nxt = ST_BAD_CHAR;
          phase_nxt  = PH_FINAL;
        end else if (b == CH_LF && term_nxt != 2'd0) begin
          role     = ROLE_TERM;
          flen_nxt = cnt_nxt;
          if (phase_nxt <= PH_VERSION)
            status_nxt = ST_BAD_LINE;
          else if (mcode_nxt == METH_NONE)
            status_nxt = ST_BAD_METHOD;
          else if (!verok_nxt || tpos_nxt < VER_LEN)
            status_nxt = ST_BAD_VERSION;
          else
            status_nxt = ST_COMPLETE;
          phase_nxt = PH_FINAL;
        end else begin
          if (b == CH_LF)
            term_nxt = 2'd1;
          else if (b == CH_CR && term_nxt == 2'd1)
            term_nxt = 2'd2;
          else
            term_nxt = 2'd0;

          // Phases fall through into the next one on the same byte.
          if (phase_nxt == PH_WS) begin
            if (b == CH_SP || b == CH_CR || b == CH_LF) begin
              role = ROLE_SKIP;
              fin  = 1'b1;
            end else begin
              phase_nxt = PH_METHOD;
            end
          end
          if (!fin && phase_nxt == PH_METHOD) begin
            fin = 1'b1;
            if (b == CH_SP) begin
              mcode_nxt = METH_NONE;
              for (int k = 0; k < METH_NUM; k++) begin
                if (cand_nxt[k] && METH_LEN[k] == tpos_nxt)
                  mcode_nxt = 4'(k + 1);
              end
              phase_nxt = PH_URI;
              role      = ROLE_SKIP;
            end else begin
              for (int k = 0; k < METH_NUM; k++) begin
                if (tpos_nxt >= METH_LEN[k] || METH_NAME[k][tpos_nxt[2:0]] != b)
                  cand_nxt[k] = 1'b0;
              end
              if (tpos_nxt != 4'd15) tpos_nxt = tpos_nxt + 4'd1;
              role = ROLE_METHOD;
            end
          end
          if (!fin && phase_nxt == PH_URI) begin
            fin = 1'b1;
            if (b == CH_SP) begin
              phase_nxt = PH_VERSION;
              tpos_nxt  = 4'd0;
              role      = ROLE_SKIP;
            end else begin
              role = ROLE_URI;
            end
          end
          if (!fin && phase_nxt == PH_VERSION) begin
            fin = 1'b1;
            if (b == CH_CR) begin
              phase_nxt = PH_DELIM;
              role      = ROLE_SKIP;
            end else begin
              if (tpos_nxt < VER_LEN && VER_PREFIX[tpos_nxt[2:0]] != b)
                verok_nxt = 1'b0;
              if (tpos_nxt != 4'd15) tpos_nxt = tpos_nxt + 4'd1;
              role = ROLE_VERSION;
            end
          end
          if (!fin && phase_nxt == PH_DELIM) begin
            if (b == CH_CR || b == CH_LF) begin
              role = ROLE_SKIP;
              fin  = 1'b1;
            end else begin
              phase_nxt  = PH_NAME;
              nempty_nxt = 1'b1;
            end
          end
          if (!fin && phase_nxt == PH_NAME) begin
            fin = 1'b1;
            if (nempty_nxt) begin
              // Colon opening a name or no room left: stop header parsing.
              if (at_limit || b == CH_COLON) begin
                phase_nxt = PH_UNPARSED;
                role      = ROLE_UNPARSED;
              end else begin
                hs_nxt     = hs_nxt + 1'b1;
                nempty_nxt = 1'b0;
                hidx       = hs_nxt - 1'b1;
                role       = ROLE_HNAME;
              end
            end else if (b == CH_COLON) begin
              phase_nxt = PH_COLSP;
              role      = ROLE_SKIP;
            end else begin
              hidx = hs_nxt - 1'b1;
              role = ROLE_HNAME;
            end
          end
          if (!fin && phase_nxt == PH_COLSP) begin
            if (b == CH_SP) begin
              role = ROLE_SKIP;
              fin  = 1'b1;
            end else begin
              phase_nxt = PH_VALUE;
            end
          end
          if (!fin && phase_nxt == PH_VALUE) begin
            fin = 1'b1;
            if (b == CH_CR || b == CH_LF) begin
              phase_nxt = PH_DELIM;
              role      = ROLE_SKIP;
            end else begin
              hidx = hs_nxt - 1'b1;
              role = ROLE_HVALUE;
            end
          end
          if (in_item.last_byte) begin
            status_nxt = ST_INCOMPLETE;
            phase_nxt  = PH_FINAL;
          end
        end
      end
    end

    res_nxt.byte_role    = role;
    res_nxt.header_index = 6'(hidx);
    res_nxt.method_code  = mcode_nxt;
    res_nxt.header_count = 7'(hs_nxt);
    res_nxt.msg_len      = 16'(flen_nxt);
    res_nxt.parse_status = status_nxt;
    res_nxt.done_res     = (status_nxt != ST_BUSY);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_WS;
      cnt_r    <= '0;
      term_r   <= 2'd0;
      cand_r   <= '1;
      tpos_r   <= 4'd0;
      hs_r     <= '0;
      nempty_r <= 1'b1;
      status_r <= ST_BUSY;
      mcode_r  <= METH_NONE;
      verok_r  <= 1'b1;
      flen_r   <= '0;
    end else if (ctl.accept) begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      term_r   <= term_nxt;
      cand_r   <= cand_nxt;
      tpos_r   <= tpos_nxt;
      hs_r     <= hs_nxt;
      nempty_r <= nempty_nxt;
      status_r <= status_nxt;
      mcode_r  <= mcode_nxt;
      verok_r  <= verok_nxt;
      flen_r   <= flen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) res_r <= res_nxt;
  end

endmodule

`default_nettype wire

// ----- hdl/http_request_header_parser_unit.sv -----
// Top level of the HTTP request header parser: handshakes, config and core.
//
// Usage: bytes of a buffered HTTP request enter on in_req, one byte per
// beat, with first_byte set on the first byte of each request and last_byte
// on the last buffered one. Each byte yields exactly one result on out_res:
// its role, header index, method code, header count, request length and the
// parse status, with done_res set once the status is final.
// cfg_wr writes header_limit (most headers recorded); it is always ready and
// should be written while no request is in flight. Reset value is 64.
// A result is registered and valid in the cycle after its byte is accepted.
// Throughput: one byte per cycle unless out_res stalls; the classifier and the
// parse-state update sit combinationally between the state and result registers.
// When out_res stalls, the pending result holds and in_req.ready drops until
// it is taken; ready rises again in the cycle the result leaves, so a stream
// keeps its rate whenever the receiver takes one result per cycle.
// Reset (rst_n low, synchronous) clears out_res.valid, clears the
// parse state and sets header_limit to 64.
`default_nettype none

module http_request_header_parser_unit
  import hrp_pkg::*;
#(
  parameter int MAX_HEADERS = HRP_MAX_HEADERS,
  parameter int LENGTH_BITS = HRP_LENGTH_BITS
) (
  input  wire logic clk,
  input  wire logic rst_n,
  hrp_in_if.sink    in_req,
  hrp_out_if.source out_res,
  hrp_cfg_if.sink   cfg_wr
);

  logic [6:0] hdr_limit_r;
  logic       out_valid_r;
  hrp_ctl_t   ctl;
  hrp_in_t    in_item;
  hrp_out_t   res_r;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_limit_r <= HDR_LIMIT_RESET;
    end else if (cfg_wr.valid) begin
      hdr_limit_r <= cfg_wr.data;
    end
  end

  // Take a new byte whenever the result slot is empty or drains now.
  assign in_req.ready     = !out_valid_r || out_res.ready;
  assign ctl.accept       = in_req.valid && in_req.ready;
  assign ctl.header_limit = hdr_limit_r;

  assign in_item.data_byte  = in_req.data_byte;
  assign in_item.first_byte = in_req.first_byte;
  assign in_item.last_byte  = in_req.last_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.accept) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  hrp_core #(
    .MAX_HEADERS (MAX_HEADERS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .in_item (in_item),
    .res_r   (res_r)
  );

  assign out_res.valid        = out_valid_r;
  assign out_res.byte_role    = res_r.byte_role;
  assign out_res.header_index = res_r.header_index;
  assign out_res.method_code  = res_r.method_code;
  assign out_res.header_count = res_r.header_count;
  assign out_res.msg_len      = res_r.msg_len;
  assign out_res.parse_status = res_r.parse_status;
  assign out_res.done_res     = res_r.done_res;

endmodule

`default_nettype wire
